FILE: rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 4096;

  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);

  localparam int SIZE_W   = 23;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = SIZE_W + 1;

  localparam int MARK_W     = 3;
  localparam int MARK_TAKEN = 0;
  localparam int MARK_FIRST = 1;
  localparam int MARK_NEXT  = 2;

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h0100_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADARG  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_RESULT
  } state_t;

endpackage

FILE: rtl/core/bpa_if.sv
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, op, size_bytes, free_address, input ready);
  modport sink   (input valid, op, size_bytes, free_address, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, address, status, input ready);
  modport sink   (input valid, address, status, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/block_table_page_allocator_top.sv
// First-fit block table allocator.
// req carries one request: op 0 allocates size_bytes rounded up to whole
// blocks, op 1 frees its run from free_address's block on. rsp returns one result
// per request: address (start of the run, zero on failure or free) and status.
// cfg writes pool_base at any handshake; write it only while no request is open.
// An allocate is accepted, then scans the table entry by entry until the
// first free run reaches the needed length, marks its blocks one by one, and
// loads the result. A free walks the chain block by block, clearing each,
// and then loads the result. Rejected requests go straight to loading the
// result. The single-port-pair mark table is read and written one entry per
// cycle. One request is in flight at a time; the next is taken once the
// result has moved to the output register.
// Reset: pool_base returns to 0x01000000 and the table is swept to free, one
// entry per cycle, during which req.ready stays low.
// A stalled rsp holds its result; a finished request waits for the output
// register to empty before the block returns to accepting requests.
module block_table_page_allocator_top import bpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);

  state_t              state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    start, start_next;
  logic [CNT_W-1:0]    run, run_next;
  logic [CNT_W-1:0]    need, need_next;
  logic [CNT_W-1:0]    mark_cnt, mark_cnt_next;
  logic [ADDR_W-1:0]   res_address, res_address_next;
  status_t             res_status, res_status_next;
  logic [ADDR_W-1:0]   pool_base;
  logic                out_valid, out_valid_next;
  logic [ADDR_W-1:0]   out_address;
  logic [STATUS_W-1:0] out_status;
  logic                out_load;

  logic                ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
  logic [MARK_W-1:0]   ram_wr_data, ram_rd_data;

  logic [SUM_W-1:0]    size_sum;
  logic [SUM_W-1:0]    need_full;
  logic [ADDR_W-1:0]   addr_diff;
  logic [ADDR_W-1:0]   blk_full;
  logic [CNT_W-1:0]    run_inc;
  logic [IDX_W-1:0]    start_cand;
  logic                at_last;

  bpa_ram #(.WIDTH(MARK_W), .DEPTH(NUM_BLOCKS)) u_marks (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign size_sum   = SUM_W'(req.size_bytes) + SUM_W'(BLOCK_BYTES - 1);
  assign need_full  = size_sum >> BLK_SHIFT;
  assign addr_diff  = req.free_address - pool_base;
  assign blk_full   = addr_diff >> BLK_SHIFT;
  assign run_inc    = run + 1'b1;
  assign start_cand = (run == '0) ? idx : start;
  assign at_last    = (idx == IDX_W'(NUM_BLOCKS - 1));

  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_valid;
  assign rsp.address = out_address;
  assign rsp.status  = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= POOL_BASE_RESET;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        pool_base <= cfg.data;
      end
      out_valid <= out_valid_next;
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    start       <= start_next;
    run         <= run_next;
    need        <= need_next;
    mark_cnt    <= mark_cnt_next;
    res_address <= res_address_next;
    res_status  <= res_status_next;
    if (out_load) begin
      out_address <= res_address;
      out_status  <= res_status;
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    start_next       = start;
    run_next         = run;
    need_next        = need;
    mark_cnt_next    = mark_cnt;
    res_address_next = res_address;
    res_status_next  = res_status;
    req.ready        = 1'b0;
    out_load         = 1'b0;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = idx;
    ram_wr_data      = '0;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = idx;

    case (state)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
        idx_next  = idx + 1'b1;
        if (at_last) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          res_address_next = '0;
          if (req.op == OP_ALLOC) begin
            if (req.size_bytes == '0) begin
              res_status_next = ST_BADARG;
              state_next      = S_RESULT;
            end else if (need_full > SUM_W'(NUM_BLOCKS)) begin
              res_status_next = ST_NOSPACE;
              state_next      = S_RESULT;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              idx_next    = '0;
              run_next    = '0;
              start_next  = '0;
              need_next   = CNT_W'(need_full);
              state_next  = S_SCAN;
            end
          end else begin
            if (req.free_address < pool_base || blk_full >= ADDR_W'(NUM_BLOCKS)) begin
              res_status_next = ST_BADARG;
              state_next      = S_RESULT;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = IDX_W'(blk_full);
              idx_next    = IDX_W'(blk_full);
              state_next  = S_FREE;
            end
          end
        end
      end

      S_SCAN: begin
        if (!ram_rd_data[MARK_TAKEN]) begin
          run_next   = run_inc;
          start_next = start_cand;
        end else begin
          run_next = '0;
        end
        if (!ram_rd_data[MARK_TAKEN] && run_inc == need) begin
          idx_next      = start_cand;
          mark_cnt_next = '0;
          state_next    = S_MARK;
        end else if (at_last) begin
          res_status_next = ST_NOSPACE;
          state_next      = S_RESULT;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx + 1'b1;
          idx_next    = idx + 1'b1;
        end
      end

      S_MARK: begin
        ram_wr_en                = 1'b1;
        ram_wr_data[MARK_TAKEN]  = 1'b1;
        ram_wr_data[MARK_FIRST]  = (mark_cnt == '0);
        ram_wr_data[MARK_NEXT]   = (mark_cnt + 1'b1 != need);
        mark_cnt_next            = mark_cnt + 1'b1;
        idx_next                 = idx + 1'b1;
        if (mark_cnt + 1'b1 == need) begin
          res_address_next = pool_base + (ADDR_W'(start) << BLK_SHIFT);
          res_status_next  = ST_OK;
          state_next       = S_RESULT;
        end
      end

      S_FREE: begin
        ram_wr_en = 1'b1;
        if (ram_rd_data[MARK_NEXT] && !at_last) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx + 1'b1;
          idx_next    = idx + 1'b1;
        end else begin
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = (out_valid && !rsp.ready) || out_load;
  end

endmodule
